@@ hw/rtl/ac3_sync_header_parser_assert.svh @@
// assertion macros used by the sync header parser rtl
// they expect clk_i and rst_ni in the enclosing module
`ifndef AC3_SYNC_HEADER_PARSER_ASSERT_SVH
`define AC3_SYNC_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define AC3_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sync header parser: check failed");

// next-cycle implication
`define AC3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sync header parser: check failed");

`endif

@@ hw/rtl/ac3_shp_pkg.sv @@
`default_nettype none

package ac3_shp_pkg;

  localparam int unsigned SizeW = 16;

  localparam logic [15:0]      SyncWord     = 16'h0B77;
  localparam logic [SizeW-1:0] MinSize      = SizeW'(8);
  localparam logic [1:0]       FscodBad     = 2'd3;
  localparam logic [4:0]       BsidExpected = 5'h08;
  localparam logic [5:0]       FrmCodes     = 6'd38;

  // status codes
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StNoSync    = 3'd1;
  localparam logic [2:0] StBadRate   = 3'd2;
  localparam logic [2:0] StBadBsid   = 3'd3;
  localparam logic [2:0] StTruncated = 3'd4;

  typedef struct packed {
    logic [15:0] sample_rate;
    logic [11:0] frame_size_bytes;
    logic [9:0]  bit_rate_kbps;
  } frame_info_t;

  typedef struct packed {
    logic [2:0]       status;
    frame_info_t      info;
    logic [2:0]       stream_mode;
    logic [SizeW-1:0] skipped_bytes;
  } result_t;

  // nominal bit rate per pair of frame size codes
  function automatic logic [9:0] rate_kbps(input logic [4:0] idx);
    logic [9:0] kb;
    case (idx)
      5'd0:    kb = 10'd32;
      5'd1:    kb = 10'd40;
      5'd2:    kb = 10'd48;
      5'd3:    kb = 10'd56;
      5'd4:    kb = 10'd64;
      5'd5:    kb = 10'd80;
      5'd6:    kb = 10'd96;
      5'd7:    kb = 10'd112;
      5'd8:    kb = 10'd128;
      5'd9:    kb = 10'd160;
      5'd10:   kb = 10'd192;
      5'd11:   kb = 10'd224;
      5'd12:   kb = 10'd256;
      5'd13:   kb = 10'd320;
      5'd14:   kb = 10'd384;
      5'd15:   kb = 10'd448;
      5'd16:   kb = 10'd512;
      5'd17:   kb = 10'd576;
      5'd18:   kb = 10'd640;
      default: kb = 10'd0;
    endcase
    return kb;
  endfunction

  // 44.1 kHz frame word count, floor(kbps * 320 / 147), before the odd-code pad
  function automatic logic [10:0] words_44k1(input logic [4:0] idx);
    logic [10:0] w;
    case (idx)
      5'd0:    w = 11'd69;
      5'd1:    w = 11'd87;
      5'd2:    w = 11'd104;
      5'd3:    w = 11'd121;
      5'd4:    w = 11'd139;
      5'd5:    w = 11'd174;
      5'd6:    w = 11'd208;
      5'd7:    w = 11'd243;
      5'd8:    w = 11'd278;
      5'd9:    w = 11'd348;
      5'd10:   w = 11'd417;
      5'd11:   w = 11'd487;
      5'd12:   w = 11'd557;
      5'd13:   w = 11'd696;
      5'd14:   w = 11'd835;
      5'd15:   w = 11'd975;
      5'd16:   w = 11'd1114;
      5'd17:   w = 11'd1253;
      5'd18:   w = 11'd1393;
      default: w = 11'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ac3_shp_frame_lookup.sv @@
`default_nettype none

module ac3_shp_frame_lookup (
  input  logic [7:0]               code_byte_i,
  output ac3_shp_pkg::frame_info_t info_o
);

  logic [1:0]  fscod;
  logic [5:0]  frm;
  logic [11:0] kb12;
  logic [11:0] words;

  assign fscod = code_byte_i[7:6];
  assign frm   = code_byte_i[5:0];
  assign kb12  = 12'(ac3_shp_pkg::rate_kbps(frm[5:1]));

  always_comb begin
    case (fscod)
      2'd0:    words = kb12 << 1;
      2'd1:    words = 12'(ac3_shp_pkg::words_44k1(frm[5:1])) + 12'(frm[0]);
      default: words = (kb12 << 1) + kb12;
    endcase
  end

  always_comb begin
    case (fscod)
      2'd0:    info_o.sample_rate = 16'd48000;
      2'd1:    info_o.sample_rate = 16'd44100;
      2'd2:    info_o.sample_rate = 16'd32000;
      default: info_o.sample_rate = 16'd0;
    endcase
    if (frm >= ac3_shp_pkg::FrmCodes) begin
      info_o.frame_size_bytes = 12'd0;
      info_o.bit_rate_kbps    = 10'd0;
    end else begin
      info_o.frame_size_bytes = words << 1;
      info_o.bit_rate_kbps    = kb12[9:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ac3_shp_header_fsm.sv @@
`default_nettype none

module ac3_shp_header_fsm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  logic [7:0]                           byte_i,
  input  logic                                 first_i,
  input  logic                                 last_i,
  input  logic [ac3_shp_pkg::SizeW-1:0]        size_i,
  input  ac3_shp_pkg::frame_info_t             info_i,
  output logic [7:0]                           code_byte_o,
  output logic                                 res_valid_o,
  output ac3_shp_pkg::result_t                 res_o
);

  typedef enum logic [2:0] {
    PhSearch,
    PhCrc1,
    PhCrc2,
    PhCode,
    PhBsi
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [15:0]                     window_q, window_d;
  logic [ac3_shp_pkg::SizeW-1:0]   skip_q, skip_d;
  logic [ac3_shp_pkg::SizeW-1:0]   limit_q, limit_d;
  logic                            full_q, full_d;
  logic [7:0]                      code_q, code_d;
  logic                            done_q, done_d;
  logic                            got;

  always_comb begin
    phase_d  = phase_q;
    window_d = window_q;
    skip_d   = skip_q;
    limit_d  = limit_q;
    full_d   = full_q;
    code_d   = code_q;
    done_d   = done_q;
    got      = 1'b0;
    res_o    = '0;
    if (step_i) begin
      if (first_i) begin
        limit_d  = (size_i >= ac3_shp_pkg::MinSize) ? size_i - ac3_shp_pkg::MinSize : '0;
        window_d = {8'h00, byte_i};
        skip_d   = '0;
        phase_d  = PhSearch;
        full_d   = 1'b0;
        code_d   = 8'h00;
        done_d   = 1'b0;
      end else if (!done_q) begin
        case (phase_q)
          PhSearch: begin
            window_d = {window_q[7:0], byte_i};
            if (!full_q) begin
              full_d = 1'b1;
            end else begin
              skip_d = skip_q + ac3_shp_pkg::SizeW'(1);
            end
            if (window_d == ac3_shp_pkg::SyncWord) begin
              phase_d = PhCrc1;
            end else if (skip_d >= limit_q) begin
              got          = 1'b1;
              res_o.status = ac3_shp_pkg::StNoSync;
            end
          end
          PhCrc1: phase_d = PhCrc2;
          PhCrc2: phase_d = PhCode;
          PhCode: begin
            if (byte_i[7:6] == ac3_shp_pkg::FscodBad) begin
              got          = 1'b1;
              res_o.status = ac3_shp_pkg::StBadRate;
            end else begin
              code_d  = byte_i;
              phase_d = PhBsi;
            end
          end
          default: begin
            got        = 1'b1;
            res_o.info = info_i;
            if (byte_i[7:3] != ac3_shp_pkg::BsidExpected) begin
              res_o.status = ac3_shp_pkg::StBadBsid;
            end else begin
              res_o.status      = ac3_shp_pkg::StOk;
              res_o.stream_mode = byte_i[2:0];
            end
          end
        endcase
      end
      // buffer ran out before a verdict
      if (!got && last_i && (first_i || !done_q)) begin
        got          = 1'b1;
        res_o.status = ac3_shp_pkg::StTruncated;
      end
      if (got) begin
        done_d = 1'b1;
      end
    end
    res_o.skipped_bytes = skip_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSearch;
      window_q <= '0;
      skip_q   <= '0;
      limit_q  <= '0;
      full_q   <= 1'b0;
      code_q   <= 8'h00;
      done_q   <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      window_q <= window_d;
      skip_q   <= skip_d;
      limit_q  <= limit_d;
      full_q   <= full_d;
      code_q   <= code_d;
      done_q   <= done_d;
    end
  end

  assign code_byte_o = code_q;
  assign res_valid_o = got;

endmodule

`default_nettype wire

@@ hw/rtl/ac3_sync_header_parser.sv @@
// a result word reaches out_valid_o through the input register and then the result register
// throughput: one byte word per cycle while the result side keeps up
// a result waiting in the result register holds the byte in the input register,
// so the input stalls from the second byte word on until the result is taken
// reset: asynchronous active low; control cleared, parser waits for a first-of-buffer byte
`default_nettype none

`include "ac3_sync_header_parser_assert.svh"

module ac3_sync_header_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          first_of_buffer_i,
  input  logic                          last_of_buffer_i,
  input  logic [ac3_shp_pkg::SizeW-1:0] buffer_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [15:0]                   sample_rate_o,
  output logic [11:0]                   frame_size_bytes_o,
  output logic [9:0]                    bit_rate_kbps_o,
  output logic [2:0]                    stream_mode_o,
  output logic [ac3_shp_pkg::SizeW-1:0] skipped_bytes_o
);

  // input register stage
  logic                          s1_valid_q, s1_valid_d;
  logic [7:0]                    s1_byte_q;
  logic                          s1_first_q;
  logic                          s1_last_q;
  logic [ac3_shp_pkg::SizeW-1:0] s1_size_q;

  // result register stage
  logic                 out_valid_q, out_valid_d;
  ac3_shp_pkg::result_t out_res_q;

  logic                     advance;
  logic                     step;
  logic [7:0]               code_byte;
  ac3_shp_pkg::frame_info_t info;
  logic                     res_valid;
  ac3_shp_pkg::result_t     res;

  // the held byte moves on whenever the result register is free or being emptied
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  assign s1_valid_d  = in_ready_o ? in_valid_i : s1_valid_q;
  assign out_valid_d = advance ? res_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q  <= data_byte_i;
      s1_first_q <= first_of_buffer_i;
      s1_last_q  <= last_of_buffer_i;
      s1_size_q  <= buffer_size_i;
    end
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  // frame size, bit rate and sample rate from the stored code byte
  ac3_shp_frame_lookup u_lookup (
    .code_byte_i (code_byte),
    .info_o      (info)
  );

  // sync search and header field walk
  ac3_shp_header_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (s1_byte_q),
    .first_i     (s1_first_q),
    .last_i      (s1_last_q),
    .size_i      (s1_size_q),
    .info_i      (info),
    .code_byte_o (code_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_res_q.status;
  assign sample_rate_o      = out_res_q.info.sample_rate;
  assign frame_size_bytes_o = out_res_q.info.frame_size_bytes;
  assign bit_rate_kbps_o    = out_res_q.info.bit_rate_kbps;
  assign stream_mode_o      = out_res_q.stream_mode;
  assign skipped_bytes_o    = out_res_q.skipped_bytes;

  // a verdict is only ever formed while the byte is allowed to move on
  `AC3_ASSERT_IMPLIES(a_res_needs_step, res_valid, step)
  // a verdict lands in the result register on the next edge
  `AC3_ASSERT_NEXT(a_res_registered, res_valid, out_valid_q)
  // an empty result register never holds back the input
  `AC3_ASSERT_IMPLIES(a_ready_when_free, !out_valid_q, in_ready_o)
  // only a clean header carries a stream mode
  `AC3_ASSERT_IMPLIES(a_mode_only_ok, out_valid_q && (out_res_q.status != ac3_shp_pkg::StOk),
                      out_res_q.stream_mode == 3'd0)
  // error verdicts without a decoded code byte carry no rate information
  `AC3_ASSERT_IMPLIES(a_no_rate_on_fail,
                      out_valid_q && (out_res_q.status != ac3_shp_pkg::StOk)
                      && (out_res_q.status != ac3_shp_pkg::StBadBsid),
                      out_res_q.info.sample_rate == 16'd0)

endmodule

`default_nettype wire
